// ===== hw/rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the streaming MD5 unit.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int QueueDepth = 4;

    localparam logic [31:0] Iv0 = 32'h67452301;
    localparam logic [31:0] Iv1 = 32'hEFCDAB89;
    localparam logic [31:0] Iv2 = 32'h98BADCFE;
    localparam logic [31:0] Iv3 = 32'h10325476;

    localparam logic [7:0] PadByte   = 8'h80;
    localparam logic [5:0] PosLenGap = 6'd55;
    localparam logic [5:0] PosLast   = 6'd63;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctl;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_ADD
    } t_core_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_BLOCK,
        B_PAD,
        B_LEN,
        B_FINAL,
        B_EMIT
    } t_back_state;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [3:0] idx);
        logic [4:0] s;
        unique case (idx)
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] g;
        lo = r[3:0];
        unique case (r[5:4])
            2'd0: g = lo;
            2'd1: g = (lo << 2) + lo + 4'd1;
            2'd2: g = (lo << 1) + lo + 4'd5;
            2'd3: g = (lo << 3) - lo;
            default: g = lo;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== hw/rtl/md5_front.sv =====
// ----------------------------------------------------------------------------
// md5_front
// Input queue: takes message beats from the stream and holds them for the
// back end, so that the source keeps going while a block is compressed, until the queue is full.
// ----------------------------------------------------------------------------
module md5_front
    import md5_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_beat i_beat,
    input  logic  i_q_pop,
    output logic  o_q_empty,
    output t_beat o_beat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_beat          r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  n_cnt;
    logic           w_wr_en;
    logic           w_rd_en;

    assign full      = (r_cnt == CW'(DEPTH));
    assign o_q_empty = (r_cnt == '0);
    assign o_beat    = r_mem[r_rd];
    assign w_wr_en   = push && !full;
    assign w_rd_en   = i_q_pop && !o_q_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr_en) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd_en && !w_wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_beat;
        end
    end

endmodule

// ===== hw/rtl/md5_core.sv =====
// ----------------------------------------------------------------------------
// md5_core
// Compression engine: one MD5 round per cycle over the block buffer, then
// folds the working words into the chaining words.
// ----------------------------------------------------------------------------
module md5_core
    import md5_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_core_ctl    i_ctl,
    output logic         o_done,
    output logic [3:0]   o_word_addr,
    input  logic [31:0]  i_word,
    output logic [127:0] o_digest
);

    t_core_state  r_state;
    t_core_state  n_state;
    logic [5:0]   r_round;
    logic [5:0]   n_round;
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [31:0]  r_h [4];
    logic [31:0]  w_f;
    logic [31:0]  w_sum;
    logic [63:0]  w_dbl;
    logic [31:0]  w_new_b;

    assign o_word_addr = msg_index(r_round);
    assign o_done      = (r_state == C_ADD);
    assign o_digest    = {swap32(r_h[0]), swap32(r_h[1]), swap32(r_h[2]), swap32(r_h[3])};

    always_comb begin
        unique case (r_round[5:4])
            2'd0: w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1: w_f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: w_f = r_b ^ r_c ^ r_d;
            2'd3: w_f = r_c ^ (r_b | ~r_d);
            default: w_f = '0;
        endcase
        w_sum   = r_a + w_f + round_k(r_round) + i_word;
        w_dbl   = {w_sum, w_sum} << rot_amt({r_round[5:4], r_round[1:0]});
        w_new_b = r_b + w_dbl[63:32];
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        unique case (r_state)
            C_IDLE: begin
                n_round = '0;
                if (i_ctl.start) begin
                    n_state = C_RUN;
                end
            end
            C_RUN: begin
                n_round = r_round + 1'b1;
                if (r_round == PosLast) begin
                    n_state = C_ADD;
                end
            end
            C_ADD: begin
                n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= Iv0;
            r_h[1] <= Iv1;
            r_h[2] <= Iv2;
            r_h[3] <= Iv3;
        end else if (r_state == C_ADD) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
        end else if (i_ctl.init) begin
            r_h[0] <= Iv0;
            r_h[1] <= Iv1;
            r_h[2] <= Iv2;
            r_h[3] <= Iv3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
        end else if (r_state == C_RUN) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= w_new_b;
        end
    end

endmodule

// ===== hw/rtl/md5_back.sv =====
// ----------------------------------------------------------------------------
// md5_back
// Back end: fills the block buffer, keeps the bit count, sequences padding
// and compressions, and holds the finished digest for the reader.
// ----------------------------------------------------------------------------
module md5_back
    import md5_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_empty,
    input  t_beat        i_beat,
    output logic         o_q_pop,
    output t_core_ctl    o_ctl,
    input  logic         i_done,
    input  logic [3:0]   i_word_addr,
    output logic [31:0]  o_word,
    input  logic [127:0] i_digest,
    output logic         empty,
    input  logic         pop,
    output logic [63:0]  o_digest_hi,
    output logic [63:0]  o_digest_lo
);

    t_back_state  r_state;
    t_back_state  n_state;
    logic [5:0]   r_pos;
    logic [5:0]   n_pos;
    logic [63:0]  r_count;
    logic [63:0]  n_count;
    logic         r_last;
    logic         n_last;
    logic         r_first;
    logic         n_first;
    logic         r_out_valid;
    logic         n_out_valid;
    logic [31:0]  r_blk [16];
    logic [63:0]  r_hi;
    logic [63:0]  r_lo;
    logic         w_byte_en;
    logic [7:0]   w_byte;
    logic         w_len_en;
    logic         w_load;
    logic         w_out_pop;

    assign o_word      = r_blk[i_word_addr];
    assign empty       = !r_out_valid;
    assign o_digest_hi = r_hi;
    assign o_digest_lo = r_lo;
    assign w_out_pop   = pop && r_out_valid;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_last    = r_last;
        n_first   = r_first;
        o_q_pop   = 1'b0;
        o_ctl     = '0;
        w_byte_en = 1'b0;
        w_byte    = i_beat.data;
        w_len_en  = 1'b0;
        w_load    = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    w_byte_en = 1'b1;
                    n_count   = r_count + 64'd8;
                    n_pos     = r_pos + 1'b1;
                    n_last    = i_beat.last;
                    if (r_pos == PosLast) begin
                        o_ctl.start = 1'b1;
                        n_state     = B_BLOCK;
                    end else if (i_beat.last) begin
                        n_state = B_PAD;
                    end
                end
            end
            B_BLOCK: begin
                if (i_done) begin
                    n_state = r_last ? B_PAD : B_IDLE;
                end
            end
            B_PAD: begin
                w_byte_en = 1'b1;
                w_byte    = r_first ? PadByte : 8'h00;
                n_first   = 1'b0;
                n_pos     = r_pos + 1'b1;
                if (r_pos == PosLenGap) begin
                    n_state = B_LEN;
                end else if (r_pos == PosLast) begin
                    o_ctl.start = 1'b1;
                    n_state     = B_BLOCK;
                end
            end
            B_LEN: begin
                w_len_en    = 1'b1;
                o_ctl.start = 1'b1;
                n_state     = B_FINAL;
            end
            B_FINAL: begin
                if (i_done) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (!r_out_valid || pop) begin
                    w_load     = 1'b1;
                    o_ctl.init = 1'b1;
                    n_count    = '0;
                    n_pos      = '0;
                    n_last     = 1'b0;
                    n_first    = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (w_out_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_last      <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_last      <= n_last;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    // block buffer and digest holding register
    always_ff @(posedge i_clk) begin
        if (w_byte_en) begin
            r_blk[r_pos[5:2]][{r_pos[1:0], 3'b000} +: 8] <= w_byte;
        end
        if (w_len_en) begin
            r_blk[14] <= r_count[31:0];
            r_blk[15] <= r_count[63:32];
        end
        if (w_load) begin
            r_hi <= i_digest[127:64];
            r_lo <= i_digest[63:0];
        end
    end

endmodule

// ===== hw/rtl/md5_stream_hash.sv =====
// ----------------------------------------------------------------------------
// md5_stream_hash
// Streaming MD5 digest unit, one message byte per beat.
// ----------------------------------------------------------------------------
// Bytes enter through a small input queue and are packed into a 64-byte block
// buffer at one byte per cycle while the back end is idle and the queue holds
// bytes. Each full block runs 64 MD5 rounds at one round per cycle and then a
// fold step, starting with the cycle after the 64th byte is taken; meanwhile the
// back end takes no bytes, and the input queue absorbs up to QUEUE_DEPTH of them.
// On the byte flagged as last the unit pads one byte per cycle up to the
// length words and runs one or two more compressions, then offers the 16-byte
// digest on the result side (byte 0 in the top bits of o_digest_hi) and
// restarts for the next message. One finished digest can wait while the next
// message is taken in.
// ----------------------------------------------------------------------------
module md5_stream_hash
    import md5_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_digest_hi,
    output logic [63:0] o_digest_lo
);

    t_beat          w_in_beat;
    t_beat          w_q_beat;
    logic           w_q_empty;
    logic           w_q_pop;
    t_core_ctl      w_ctl;
    logic           w_done;
    logic [3:0]     w_word_addr;
    logic [31:0]    w_word;
    logic [127:0]   w_digest;

    assign w_in_beat.data = i_data_byte;
    assign w_in_beat.last = i_last_byte;

    md5_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_beat    (w_in_beat),
        .i_q_pop   (w_q_pop),
        .o_q_empty (w_q_empty),
        .o_beat    (w_q_beat)
    );

    md5_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_done      (w_done),
        .o_word_addr (w_word_addr),
        .i_word      (w_word),
        .o_digest    (w_digest)
    );

    md5_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_beat      (w_q_beat),
        .o_q_pop     (w_q_pop),
        .o_ctl       (w_ctl),
        .i_done      (w_done),
        .i_word_addr (w_word_addr),
        .o_word      (w_word),
        .i_digest    (w_digest),
        .empty       (empty),
        .pop         (pop),
        .o_digest_hi (o_digest_hi),
        .o_digest_lo (o_digest_lo)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming MD5 unit. Whole messages are pushed a
// byte per beat: a short table of known vectors and byte extremes first, then
// random messages biased towards the padding boundaries. A local MD5 model
// predicts each digest that the table does not give. Both sides idle at random, and the digest side holds
// off for one long stretch so that the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_BYTES  = 1400;
    localparam int RAND_MSGS   = 10;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_WAIT  = 300;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    localparam int PAD_LENS [13] = '{1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_digest;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_row;

    // known vectors: "a", "abc", single 0x00, single 0xff, ff 00, "message digest"
    t_row directed_rows [22] = '{
        {8'h61, 1'b1, 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661},
        {8'h61, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h62, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h63, 1'b1, 1'b1, 64'h900150983cd24fb0, 64'hd6963f7d28e17f72},
        {8'h00, 1'b1, 1'b0, 64'h0, 64'h0},
        {8'hff, 1'b1, 1'b0, 64'h0, 64'h0},
        {8'hff, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h00, 1'b1, 1'b0, 64'h0, 64'h0},
        {8'h6d, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h65, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h73, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h73, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h61, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h67, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h65, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h20, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h64, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h69, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h67, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h65, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h73, 1'b0, 1'b0, 64'h0, 64'h0},
        {8'h74, 1'b1, 1'b1, 64'hf96b697d7cb7938d, 64'h525a2f31aaf161d0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        empty;
    logic        pop;
    logic [63:0] o_digest_hi;
    logic [63:0] o_digest_lo;

    logic [31:0] chain [4];
    logic [7:0]  msg_block [64];
    logic [63:0] len_bits;

    t_digest digest_q [$];

    int unsigned mismatches;
    int unsigned digests_seen;
    int unsigned rand_sent;
    int unsigned cycles;
    bit          calm;
    bit          hold_pop;

    md5_stream_hash u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .empty       (empty),
        .pop         (pop),
        .o_digest_hi (o_digest_hi),
        .o_digest_lo (o_digest_lo)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic restart_hash();
        chain[0] = 32'h67452301;
        chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe;
        chain[3] = 32'h10325476;
        len_bits = '0;
    endtask

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic fold_block();
        logic [31:0] a, b, c, d, f, t, w;
        int          g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            w = {msg_block[4*g+3], msg_block[4*g+2], msg_block[4*g+1], msg_block[4*g]};
            t = d;
            d = c;
            c = b;
            b = b + rotl32(a + f + SINE_K[r] + w, ROT_S[(r / 16) * 4 + r % 4]);
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endtask

    task automatic absorb_byte(input logic [7:0] d, input logic l, output bit done,
                               output t_digest dg);
        int pos;
        pos = int'(len_bits[8:3]);
        msg_block[pos] = d;
        len_bits = len_bits + 64'd8;
        pos = (pos + 1) % 64;
        if (pos == 0) fold_block();
        done = 1'b0;
        dg = '0;
        if (l) begin
            msg_block[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                for (int i = pos; i < 64; i++) msg_block[i] = 8'h00;
                fold_block();
                pos = 0;
            end
            for (int i = pos; i < 56; i++) msg_block[i] = 8'h00;
            for (int i = 0; i < 8; i++) msg_block[56 + i] = len_bits[8*i +: 8];
            fold_block();
            dg.hi = {chain[0][7:0], chain[0][15:8], chain[0][23:16], chain[0][31:24],
                     chain[1][7:0], chain[1][15:8], chain[1][23:16], chain[1][31:24]};
            dg.lo = {chain[2][7:0], chain[2][15:8], chain[2][23:16], chain[2][31:24],
                     chain[3][7:0], chain[3][15:8], chain[3][23:16], chain[3][31:24]};
            done = 1'b1;
            restart_hash();
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                             input t_digest known);
        int unsigned gap;
        bit          done;
        t_digest     dg;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push        <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        absorb_byte(d, l, done, dg);
        if (done) digest_q.push_back(typed ? known : dg);
    endtask

    task automatic flag_field(input string field, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("digest %0d %s: expected %h, got %h", digests_seen, field, want, got);
    endtask

    // digest side
    always @(posedge i_clk) begin
        t_digest want;
        if (i_rst_n && pop && !empty) begin
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest %h %h", o_digest_hi, o_digest_lo);
            end else begin
                want = digest_q.pop_front();
                if (o_digest_hi !== want.hi) flag_field("hi", want.hi, o_digest_hi);
                if (o_digest_lo !== want.lo) flag_field("lo", want.lo, o_digest_lo);
            end
            digests_seen++;
        end
    end

    initial begin : pop_side
        int unsigned idle;
        idle = 0;
        pop  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pop || idle > 0) begin
                pop <= 1'b0;
                if (idle > 0) idle--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0) idle = pick_gap();
            end
        end
    end

    // stretches with no idling on either side
    initial begin
        calm = 1'b0;
        forever begin
            repeat ($urandom_range(200, 800)) @(posedge i_clk);
            calm = ($urandom_range(0, 2) == 0);
        end
    end

    // long hold-off on the digest side so the unit backs up
    initial begin
        hold_pop = 1'b0;
        wait (rand_sent >= 200);
        hold_pop = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_pop = 1'b0;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned len;
        int unsigned mode;
        int unsigned msgs;
        logic [7:0]  d;
        mismatches   = 0;
        digests_seen = 0;
        rand_sent    = 0;
        msgs         = 0;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_data_byte  = 8'h00;
        i_last_byte  = 1'b0;
        restart_hash();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                      {directed_rows[i].hi, directed_rows[i].lo});

        while (rand_sent < RAND_BYTES || msgs < RAND_MSGS) begin
            if ($urandom_range(0, 9) < 4) len = PAD_LENS[$urandom_range(0, 12)];
            else if ($urandom_range(0, 5) != 0) len = $urandom_range(1, 70);
            else len = $urandom_range(71, 200);
            mode = $urandom_range(0, 9);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0: d = 8'hff;
                    1: d = 8'h00;
                    default: d = 8'($urandom_range(0, 255));
                endcase
                send_byte(d, k == len - 1, 1'b0, '0);
                rand_sent++;
            end
            msgs++;
        end
        @(negedge i_clk);
        push <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && digest_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
